// ===== rtl/efe_pkg.sv =====
// Shared types, constants and register map of the ensemble fractile extractor.
`default_nettype none

package efe_pkg;

    localparam int MAX_MEMBERS = 64;
    localparam int ADDR_W      = $clog2(MAX_MEMBERS);
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int RANK_W      = 6;
    localparam int SLOT_COUNT  = 7;
    localparam int SLOT_W      = 3;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [CNT_W-1:0]  COUNT_RESET       = 7'd51;
    localparam logic [RANK_W-1:0] RANK_MIN_RESET    = 6'd0;
    localparam logic [RANK_W-1:0] RANK_P10_RESET    = 6'd4;
    localparam logic [RANK_W-1:0] RANK_P25_RESET    = 6'd12;
    localparam logic [RANK_W-1:0] RANK_MEDIAN_RESET = 6'd25;
    localparam logic [RANK_W-1:0] RANK_P75_RESET    = 6'd37;
    localparam logic [RANK_W-1:0] RANK_P90_RESET    = 6'd45;
    localparam logic [RANK_W-1:0] RANK_MAX_RESET    = 6'd50;

    typedef enum logic [2:0] {
        REG_MEMBER_COUNT = 3'd0,
        REG_RANK_MIN     = 3'd1,
        REG_RANK_P10     = 3'd2,
        REG_RANK_P25     = 3'd3,
        REG_RANK_MEDIAN  = 3'd4,
        REG_RANK_P75     = 3'd5,
        REG_RANK_P90     = 3'd6,
        REG_RANK_MAX     = 3'd7
    } cfg_reg_t;

    typedef logic [RANK_W-1:0] rank_t;
    typedef rank_t [SLOT_COUNT-1:0] rank_arr_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SHIFT   = 2'd1,
        ST_SEL_RD  = 2'd2,
        ST_SEL_OUT = 2'd3
    } state_t;

    typedef struct packed {
        logic load_item;
        logic shift_step;
        logic insert;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic greater;
        logic gather_done;
        logic slot_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/efe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module efe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/efe_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module efe_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [efe_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [efe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [efe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output logic      [efe_pkg::CNT_W-1:0]      member_count,
    output efe_pkg::rank_arr_t                  ranks
);
    import efe_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    rank_arr_t        rank_reg, rank_next;
    cfg_reg_t         index;
    logic             wr_en;

    assign pready = 1'b1;
    assign index  = cfg_reg_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        count_next = count_reg;
        rank_next  = rank_reg;
        if (wr_en) begin
            case (index)
                REG_MEMBER_COUNT: count_next   = pwdata[CNT_W-1:0];
                REG_RANK_MIN:     rank_next[0] = pwdata[RANK_W-1:0];
                REG_RANK_P10:     rank_next[1] = pwdata[RANK_W-1:0];
                REG_RANK_P25:     rank_next[2] = pwdata[RANK_W-1:0];
                REG_RANK_MEDIAN:  rank_next[3] = pwdata[RANK_W-1:0];
                REG_RANK_P75:     rank_next[4] = pwdata[RANK_W-1:0];
                REG_RANK_P90:     rank_next[5] = pwdata[RANK_W-1:0];
                REG_RANK_MAX:     rank_next[6] = pwdata[RANK_W-1:0];
                default:          count_next   = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= COUNT_RESET;
            rank_reg[0] <= RANK_MIN_RESET;
            rank_reg[1] <= RANK_P10_RESET;
            rank_reg[2] <= RANK_P25_RESET;
            rank_reg[3] <= RANK_MEDIAN_RESET;
            rank_reg[4] <= RANK_P75_RESET;
            rank_reg[5] <= RANK_P90_RESET;
            rank_reg[6] <= RANK_MAX_RESET;
        end else begin
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_comb begin
        case (index)
            REG_MEMBER_COUNT: prdata = CFG_DATA_W'(count_reg);
            REG_RANK_MIN:     prdata = CFG_DATA_W'(rank_reg[0]);
            REG_RANK_P10:     prdata = CFG_DATA_W'(rank_reg[1]);
            REG_RANK_P25:     prdata = CFG_DATA_W'(rank_reg[2]);
            REG_RANK_MEDIAN:  prdata = CFG_DATA_W'(rank_reg[3]);
            REG_RANK_P75:     prdata = CFG_DATA_W'(rank_reg[4]);
            REG_RANK_P90:     prdata = CFG_DATA_W'(rank_reg[5]);
            REG_RANK_MAX:     prdata = CFG_DATA_W'(rank_reg[6]);
            default:          prdata = '0;
        endcase
    end

    assign member_count = count_reg;
    assign ranks        = rank_reg;

endmodule

`default_nettype wire

// ===== rtl/efe_ctrl.sv =====
// Controller state machine: insertion steps and the seven-word selection sequence.
`default_nettype none

module efe_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  efe_pkg::status_t status,
    output efe_pkg::cmd_t    cmd
);
    import efe_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (status.pos_zero || !status.greater) begin
                    state_next = status.gather_done ? ST_SEL_RD : ST_IDLE;
                end
            end
            ST_SEL_RD: begin
                state_next = ST_SEL_OUT;
            end
            ST_SEL_OUT: begin
                if (status.out_free) begin
                    state_next = status.slot_last ? ST_IDLE : ST_SEL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_SHIFT: begin
                // Move the larger neighbor up one place, or drop the new word into the gap.
                if (!status.pos_zero && status.greater) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    cmd.insert = 1'b1;
                end
            end
            ST_SEL_OUT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/efe_dp.sv =====
// Datapath: sorted member store, insertion pointer, rank selection and output register.
`default_nettype none

module efe_dp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  efe_pkg::cmd_t                   cmd,
    output efe_pkg::status_t                status,
    input  wire logic [efe_pkg::CNT_W-1:0]  member_count,
    input  efe_pkg::rank_arr_t              ranks,
    input  wire logic [efe_pkg::DATA_W-1:0] in_value,
    output logic      [efe_pkg::DATA_W-1:0] out_value,
    output logic      [efe_pkg::SLOT_W-1:0] out_slot,
    output logic                            out_last,
    output logic                            out_valid,
    input  wire logic                       out_ready
);
    import efe_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]         seen_reg, seen_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [DATA_W-1:0]        out_value_reg, out_value_next;
    logic [SLOT_W-1:0]        out_slot_reg, out_slot_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  held;
    rank_t             rank_sel;
    logic [ADDR_W-1:0] sel_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              ram_we;
    logic [DATA_W-1:0] ram_wdata;

    efe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_MEMBERS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // A count of zero acts as one, a count past the store depth as the depth.
    always_comb begin
        if (member_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (member_count > CNT_W'(MAX_MEMBERS)) begin
            eff_count = CNT_W'(MAX_MEMBERS);
        end else begin
            eff_count = member_count;
        end
    end

    assign held = seen_reg + CNT_W'(1);

    // Ranks past the last held member saturate to the largest one.
    assign rank_sel = ranks[slot_reg];
    assign sel_addr = (CNT_W'(rank_sel) > seen_reg) ? seen_reg[ADDR_W-1:0]
                                                    : ADDR_W'(rank_sel);

    // The read runs one place ahead of the write, so a shift step needs no separate read.
    always_comb begin
        if (cmd.load_item) begin
            rd_addr = seen_reg[ADDR_W-1:0] - ADDR_W'(1);
        end else if (cmd.shift_step) begin
            rd_addr = pos_reg - ADDR_W'(2);
        end else begin
            rd_addr = sel_addr;
        end
    end

    assign ram_we    = cmd.shift_step || cmd.insert;
    assign ram_wdata = cmd.shift_step ? rd_data : value_reg;

    always_comb begin
        value_next     = value_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        slot_next      = slot_reg;
        out_value_next = out_value_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (cmd.load_item) begin
            value_next = in_value;
            pos_next   = seen_reg[ADDR_W-1:0];
            slot_next  = '0;
        end
        if (cmd.shift_step) begin
            pos_next = pos_reg - ADDR_W'(1);
        end
        if (cmd.insert && !status.gather_done) begin
            seen_next = held;
        end
        if (cmd.out_load) begin
            out_value_next = rd_data;
            out_slot_next  = slot_reg;
            out_last_next  = (slot_reg == SLOT_LAST);
            out_valid_next = 1'b1;
            slot_next      = slot_reg + SLOT_W'(1);
            if (slot_reg == SLOT_LAST) begin
                seen_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg     <= value_next;
        pos_reg       <= pos_next;
        slot_reg      <= slot_next;
        out_value_reg <= out_value_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    assign status.pos_zero    = (pos_reg == '0);
    assign status.greater     = ($signed(rd_data) > value_reg);
    assign status.gather_done = (held >= eff_count);
    assign status.slot_last   = (slot_reg == SLOT_LAST);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_value = out_value_reg;
    assign out_slot  = out_slot_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/ensemble_fractile_extractor_top.sv =====
// Top level of the ensemble fractile extractor.
//
//   channel   direction  words                  payload
//   s_        in         one member value       tdata = member_value
//   m_        out        seven per grid point   tdata = fractile_value,
//                                               tuser = fractile_slot, tlast = is_last
//   apb       in/out     register access        eight registers at 4*index
//
// A member word shifts each held member larger than it up one place before it is written;
// the single-port write of the sorted store moves one member per cycle.
// The word that completes a grid point then reads and loads each result in turn.
// Reset is synchronous on aresetn low; the store needs no clearing pass.
// A stalled result holds in the output register while the next member is taken.
`default_nettype none

module ensemble_fractile_extractor_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,   // [31:0] member_value
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [31:0]                    m_tdata,   // [31:0] fractile_value
    output logic      [2:0]                     m_tuser,   // [2:0] fractile_slot
    output logic                                m_tlast,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [efe_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [efe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [efe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import efe_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [CNT_W-1:0] member_count;
    rank_arr_t        ranks;

    efe_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .member_count (member_count),
        .ranks        (ranks)
    );

    efe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    efe_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .member_count (member_count),
        .ranks        (ranks),
        .in_value     (s_tdata),
        .out_value    (m_tdata),
        .out_slot     (m_tuser),
        .out_last     (m_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

`ifndef SYNTHESIS
    // The output register is never overwritten while it still holds an untaken word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending word");

    // After a member word is taken, the insertion runs before the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted during insertion");

    // The last selection shows up as a valid word marked last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && status.slot_last) |=> (m_tvalid && m_tlast))
        else $error("last result of a grid point not marked");

    // A shift never walks past the bottom of the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_step |-> !status.pos_zero)
        else $error("shift below position zero");
`endif

endmodule

`default_nettype wire
